// ===== src/decimal_digit_display_frame_emitter_macros.svh =====
// Assertion macros for the decimal digit display frame emitter.
// Included by the top level; needs clk and rst in scope at the point of use.
`ifndef DECIMAL_DIGIT_DISPLAY_FRAME_EMITTER_MACROS_SVH
`define DECIMAL_DIGIT_DISPLAY_FRAME_EMITTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off during reset
`define DDFE_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ddfe assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define DDFE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ddfe assertion failed");

`else

`define DDFE_ASSERT_SAME(lbl, pre, post)
`define DDFE_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ===== src/ddfe_pkg.sv =====
// Shared types, constants and helper functions for the display frame emitter.
// No dependencies; used by ddfe_serializer and the top level.
package ddfe_pkg;

  localparam int VALUE_W = 31;
  localparam int COUNT_W = 4;
  localparam int POS_W   = 4;
  localparam int CODE_W  = 4;
  localparam int FRAME_W = 16;
  localparam int BYTE_W  = 8;

  localparam logic [CODE_W-1:0] BLANK_CODE = 4'd15;

  // Reciprocal of ten for an exact 32-bit divide: q = (v * RECIP10) >> RECIP_SHIFT
  localparam int PROD_W      = VALUE_W + 32;
  localparam int RECIP_SHIFT = 35;
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  // Word handed from the digit pipeline to the serializer
  typedef struct packed {
    logic valid;
    logic overflow;
  } run_t;

  // Divide by ten through one multiply
  function automatic logic [VALUE_W-1:0] div10(input logic [VALUE_W-1:0] v);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(v) * PROD_W'(RECIP10);
    return VALUE_W'(prod[PROD_W-1:RECIP_SHIFT]);
  endfunction

  // Digit from the low bits of a value and of its quotient; blank past the count
  function automatic logic [CODE_W-1:0] digit_code(input logic [3:0]         prev_lo,
                                                   input logic [3:0]         q_lo,
                                                   input logic [COUNT_W-1:0] count,
                                                   input logic [COUNT_W-1:0] pos);
    logic [3:0] d;
    d = prev_lo - {q_lo[0], 3'b000} - {q_lo[2:0], 1'b0};
    return (count >= pos) ? CODE_W'(d) : BLANK_CODE;
  endfunction

endpackage

// ===== src/ddfe_serializer.sv =====
// Frame serializer: holds one finished run of digit codes and emits one frame per cycle while out_stall is low.
// Depends on ddfe_pkg.
module ddfe_serializer #(
  parameter int NUM_POSITIONS = 8
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  ddfe_pkg::run_t                              run,
  input  logic [NUM_POSITIONS*ddfe_pkg::CODE_W-1:0]   codes,
  output logic                                        take,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic [ddfe_pkg::POS_W-1:0]                  position,
  output logic [ddfe_pkg::CODE_W-1:0]                 digit_code,
  output logic [ddfe_pkg::FRAME_W-1:0]                frame,
  output logic                                        last,
  output logic                                        overflow
);

  localparam int CODES_W = NUM_POSITIONS * ddfe_pkg::CODE_W;

  logic                        busy;
  logic [ddfe_pkg::POS_W-1:0]  pos;
  logic [CODES_W-1:0]          shreg;
  logic                        ovf;
  logic                        at_last;

  assign at_last = (pos == ddfe_pkg::POS_W'(NUM_POSITIONS));

  // Load a new run when idle or when the final frame leaves this cycle
  assign take = !busy || (at_last && !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (take) begin
      busy <= run.valid;
    end
  end

  // Position counter and code shifter
  always_ff @(posedge clk) begin
    if (take) begin
      pos   <= ddfe_pkg::POS_W'(1);
      shreg <= codes;
      ovf   <= run.overflow;
    end else if (!out_stall) begin
      pos   <= pos + ddfe_pkg::POS_W'(1);
      shreg <= shreg >> ddfe_pkg::CODE_W;
    end
  end

  // Output word
  assign out_valid  = busy;
  assign position   = pos;
  assign digit_code = shreg[ddfe_pkg::CODE_W-1:0];
  assign frame      = {ddfe_pkg::BYTE_W'(pos), ddfe_pkg::BYTE_W'(shreg[ddfe_pkg::CODE_W-1:0])};
  assign last       = at_last;
  assign overflow   = at_last && ovf;

endmodule

// ===== src/decimal_digit_display_frame_emitter.sv =====
// Top level of the decimal digit display frame emitter.
// Depends on ddfe_pkg, ddfe_serializer and the assertion macro header.
`include "decimal_digit_display_frame_emitter_macros.svh"

// Each accepted word (value, digit_count) produces NUM_POSITIONS display frames,
// positions 1 upward, least significant decimal digit first; positions above
// digit_count carry blank code 15, and the final frame has last set and flags
// overflow when value does not fit in NUM_POSITIONS decimal digits. Digits are
// formed in a pipeline of NUM_POSITIONS + 2 register stages, one divide-by-ten
// multiply in each stage but the input stage and the final stage. The output
// serializer sends one frame per cycle while out_stall is low. The pipeline
// keeps accepting words while earlier frames are still being sent until its
// last stage holds a finished word that the serializer cannot take yet;
// in_stall is then high and every stage holds, so the whole pipeline waits
// until the final frame of the run in progress is accepted.
module decimal_digit_display_frame_emitter #(
  parameter int NUM_POSITIONS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ddfe_pkg::VALUE_W-1:0]    value,
  input  logic [ddfe_pkg::COUNT_W-1:0]    digit_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ddfe_pkg::POS_W-1:0]      position,
  output logic [ddfe_pkg::CODE_W-1:0]     digit_code,
  output logic [ddfe_pkg::FRAME_W-1:0]    frame,
  output logic                            last,
  output logic                            overflow
);

  localparam int N       = NUM_POSITIONS;
  localparam int CW      = ddfe_pkg::CODE_W;
  localparam int CODES_W = N * CW;

  // Stage 0 holds the input; stages 1..N divide; stage N+1 finishes the last digit
  logic [N+1:0]                 vld;
  logic [ddfe_pkg::VALUE_W-1:0] rest    [0:N];
  logic [ddfe_pkg::COUNT_W-1:0] cnt     [0:N];
  logic [3:0]                   prev_lo [1:N];
  logic [CODES_W-1:0]           codes   [1:N+1];
  logic                         ovf;

  logic                         adv;
  logic                         take;
  ddfe_pkg::run_t               run;

  // Whole pipeline moves together whenever its tail is free or drained
  assign adv      = !vld[N+1] || take;
  assign in_stall = !adv;

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rest[0] <= value;
      cnt[0]  <= digit_count;
    end
  end

  // Divide stages: stage s takes value / 10^(s-1) and settles digit s-1
  for (genvar s = 1; s <= N; s++) begin : g_div
    logic [CODES_W-1:0] codes_next;

    if (s == 1) begin : g_first
      assign codes_next = {N{ddfe_pkg::BLANK_CODE}};
    end else begin : g_fill
      always_comb begin
        codes_next = codes[s-1];
        codes_next[(s-2)*CW +: CW] = ddfe_pkg::digit_code(prev_lo[s-1], rest[s-1][3:0],
                                                          cnt[s-1],
                                                          ddfe_pkg::COUNT_W'(s-1));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rest[s]    <= ddfe_pkg::div10(rest[s-1]);
        prev_lo[s] <= rest[s-1][3:0];
        cnt[s]     <= cnt[s-1];
        codes[s]   <= codes_next;
      end
    end
  end

  // Final stage: last digit and overflow
  logic [CODES_W-1:0] codes_fin;

  always_comb begin
    codes_fin = codes[N];
    codes_fin[(N-1)*CW +: CW] = ddfe_pkg::digit_code(prev_lo[N], rest[N][3:0], cnt[N],
                                                     ddfe_pkg::COUNT_W'(N));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[N+1] <= 1'b0;
    end else if (adv) begin
      vld[N+1] <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      codes[N+1] <= codes_fin;
      ovf        <= (rest[N] != '0);
    end
  end

  assign run.valid    = vld[N+1];
  assign run.overflow = ovf;

  // Output serializer
  ddfe_serializer #(
    .NUM_POSITIONS(NUM_POSITIONS)
  ) u_ser (
    .clk       (clk),
    .rst       (rst),
    .run       (run),
    .codes     (codes[N+1]),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .position  (position),
    .digit_code(digit_code),
    .frame     (frame),
    .last      (last),
    .overflow  (overflow)
  );

  // Checks
  `DDFE_ASSERT_SAME(a_idle_takes_input, !out_valid, !in_stall)
  `DDFE_ASSERT_SAME(a_code_range, out_valid && digit_code != ddfe_pkg::BLANK_CODE, digit_code <= 4'd9)
  `DDFE_ASSERT_SAME(a_ovf_only_last, out_valid && !last, !overflow)
  `DDFE_ASSERT_NEXT(a_pos_steps, out_valid && !last && !out_stall, out_valid && position == $past(position) + 4'd1)

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for decimal_digit_display_frame_emitter.
// Needs ddfe_pkg and the emitter RTL; drives words through valid/stall and
// checks every frame against directed expected codes or a built-in digit predictor.
module tb;

  localparam int NUM_POS     = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 88;
  localparam int QUIET_WORDS  = 20;

  localparam int VW = ddfe_pkg::VALUE_W;
  localparam int KW = ddfe_pkg::COUNT_W;
  localparam int PW = ddfe_pkg::POS_W;
  localparam int CW = ddfe_pkg::CODE_W;
  localparam int FW = ddfe_pkg::FRAME_W;
  localparam int BW = ddfe_pkg::BYTE_W;

  // One row of the directed plan; codes hold position 1 in the low nibble
  typedef struct packed {
    logic [VW-1:0] value;
    logic [KW-1:0] count;
    logic          typed;
    logic [31:0]   codes;
    logic          ovf;
  } plan_row_t;

  // One expected display frame
  typedef struct {
    logic [PW-1:0] position;
    logic [CW-1:0] digit_code;
    logic [FW-1:0] frame;
    logic          last;
    logic          overflow;
  } frame_exp_t;

  localparam int PLAN_ROWS = 22;
  plan_row_t plan [PLAN_ROWS] = '{
    '{31'd0,          4'd8,  1'b1, 32'h00000000, 1'b0},
    '{31'd12345678,   4'd8,  1'b1, 32'h12345678, 1'b0},
    '{31'd12345678,   4'd0,  1'b1, 32'hFFFFFFFF, 1'b0},
    '{31'd12345678,   4'd4,  1'b1, 32'hFFFF5678, 1'b0},
    '{31'd99999999,   4'd8,  1'b1, 32'h99999999, 1'b0},
    '{31'd100000000,  4'd8,  1'b1, 32'h00000000, 1'b1},
    '{31'd2147483647, 4'd8,  1'b1, 32'h47483647, 1'b1},
    '{31'd2147483647, 4'd15, 1'b1, 32'h47483647, 1'b1},
    '{31'd2147483647, 4'd0,  1'b1, 32'hFFFFFFFF, 1'b1},
    '{31'd5,          4'd1,  1'b1, 32'hFFFFFFF5, 1'b0},
    '{31'd12345678,   4'd9,  1'b1, 32'h12345678, 1'b0},
    '{31'd0,          4'd0,  1'b1, 32'hFFFFFFFF, 1'b0},
    '{31'd87654321,   4'd7,  1'b1, 32'hF7654321, 1'b0},
    '{31'd10000000,   4'd8,  1'b1, 32'h10000000, 1'b0},
    '{31'd100000000,  4'd3,  1'b1, 32'hFFFFF000, 1'b1},
    '{31'd9,          4'd12, 1'b1, 32'h00000009, 1'b0},
    '{31'h40000000,   4'd10, 1'b0, 32'h0, 1'b0},
    '{31'h55555555,   4'd6,  1'b0, 32'h0, 1'b0},
    '{31'h2AAAAAAA,   4'd5,  1'b0, 32'h0, 1'b0},
    '{31'd999999999,  4'd2,  1'b0, 32'h0, 1'b0},
    '{31'h7FFFFFFE,   4'd14, 1'b0, 32'h0, 1'b0},
    '{31'd100000001,  4'd13, 1'b0, 32'h0, 1'b0}
  };

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  logic [VW-1:0]  value = '0;
  logic [KW-1:0]  digit_count = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic [PW-1:0]  position;
  logic [CW-1:0]  digit_code;
  logic [FW-1:0]  frame;
  logic           last;
  logic           overflow;

  frame_exp_t frames_due[$];
  int  mismatches = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;
  int  stall_burst = 0;

  decimal_digit_display_frame_emitter #(.NUM_POSITIONS(NUM_POS)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .value(value), .digit_count(digit_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .position(position), .digit_code(digit_code), .frame(frame),
    .last(last), .overflow(overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Digit predictor: returns {overflow, codes}, position 1 in the low nibble
  function automatic logic [32:0] decimal_codes(input logic [VW-1:0] v,
                                                input logic [KW-1:0] cnt);
    int unsigned rest;
    int unsigned shown;
    logic [31:0] codes;
    rest  = v;
    shown = (cnt > NUM_POS) ? NUM_POS : cnt;
    codes = '1;
    for (int p = 1; p <= NUM_POS; p++) begin
      codes[(p-1)*4 +: 4] = (p <= shown) ? CW'(rest % 10) : ddfe_pkg::BLANK_CODE;
      rest = rest / 10;
    end
    return {rest != 0, codes};
  endfunction

  // Expand a digit set into the eight frames that must follow
  function automatic void queue_frames(input logic [31:0] codes, input logic ovf);
    frame_exp_t f;
    for (int p = 1; p <= NUM_POS; p++) begin
      f.position   = PW'(p);
      f.digit_code = codes[(p-1)*4 +: 4];
      f.frame      = {BW'(p), BW'(f.digit_code)};
      f.last       = (p == NUM_POS);
      f.overflow   = (p == NUM_POS) && ovf;
      frames_due.push_back(f);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Drive one word from a falling edge, hold it through stall, return on a falling edge
  task automatic send_word(input logic [VW-1:0] v, input logic [KW-1:0] cnt,
                           input logic typed, input logic [31:0] codes, input logic ovf);
    logic [32:0] pred;
    in_valid    = 1'b1;
    value       = v;
    digit_count = cnt;
    do @(posedge clk); while (in_stall);
    pred = decimal_codes(v, cnt);
    if (typed) queue_frames(codes, ovf);
    else       queue_frames(pred[31:0], pred[32]);
    @(negedge clk);
    // random sender gap
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  // Random word values, biased toward the eight-digit boundary
  function automatic logic [VW-1:0] pick_value();
    int unsigned p10;
    p10 = 1;
    unique case ($urandom_range(0, 4))
      0: return VW'($urandom());
      1: return VW'($urandom_range(0, 99999999));
      2: return VW'($urandom_range(99999990, 100000010));
      3: begin
        repeat ($urandom_range(0, 9)) p10 = p10 * 10;
        return VW'(p10 - $urandom_range(0, 1));
      end
      default: return VW'($urandom_range(0, 999));
    endcase
  endfunction

  // Receiver stall bursts
  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
    end else if (stall_burst > 0) begin
      stall_burst <= stall_burst - 1;
    end else begin
      out_stall   <= ($urandom_range(0, 2) == 0);
      stall_burst <= $urandom_range(1, 16);
    end
  end

  // Frame checker
  always @(posedge clk) begin
    frame_exp_t f;
    if (!rst && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        $error("unexpected frame: position %0d code %0d", position, digit_code);
        mismatches++;
      end else begin
        f = frames_due.pop_front();
        check_field("position", f.position, position);
        check_field("digit_code", f.digit_code, digit_code);
        check_field("frame", f.frame, frame);
        check_field("last", f.last, last);
        check_field("overflow", f.overflow, overflow);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [KW-1:0] cnt;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed plan
    foreach (plan[i])
      send_word(plan[i].value, plan[i].count, plan[i].typed, plan[i].codes, plan[i].ovf);

    // random words, quiet tail with no idling
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS - QUIET_WORDS) quiet = 1'b1;
      cnt = ($urandom_range(0, 3) == 0) ? KW'($urandom_range(0, 15))
                                        : KW'($urandom_range(1, 8));
      send_word(pick_value(), cnt, 1'b0, 32'h0, 1'b0);
    end
    in_valid = 1'b0;

    // drain
    while (frames_due.size() != 0) @(posedge clk);
    repeat (NUM_POS + 4) @(posedge clk);

    if (mismatches == 0 && frames_due.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
